>>> rtl/spe_pkg.sv
// Package with the shared constants, types and codes of the sparse polynomial evaluator.
`timescale 1ns / 1ps
`default_nettype none
package spe_pkg;

  localparam int MAX_TERMS   = 16;
  localparam int DATA_W      = 32;
  localparam int EXP_W       = 6;
  localparam int TERM_IDX_W  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int TERM_CNT_W  = $clog2(MAX_TERMS + 1);
  localparam int POW_IDX_W   = $clog2(EXP_W);

  localparam int CMD_Q_DEPTH = 4;
  localparam int CMD_Q_PTR_W = $clog2(CMD_Q_DEPTH);
  localparam int CMD_Q_CNT_W = $clog2(CMD_Q_DEPTH + 1);

  localparam int RES_Q_DEPTH = 2;
  localparam int RES_Q_PTR_W = $clog2(RES_Q_DEPTH);
  localparam int RES_Q_CNT_W = $clog2(RES_Q_DEPTH + 1);

  typedef enum logic {
    KIND_ADD  = 1'b0,
    KIND_EVAL = 1'b1
  } kind_t;

  // One classified request: the operand is the coefficient of an add or the
  // point of an evaluate.
  typedef struct packed {
    kind_t              kind;
    logic               first_term;
    logic [DATA_W-1:0]  operand;
    logic [EXP_W-1:0]   exponent;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] coef;
    logic [EXP_W-1:0]  exp;
  } term_t;

  typedef struct packed {
    logic [DATA_W-1:0] poly_value;
    logic              terms_dropped;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POW,
    ST_READ,
    ST_LOAD,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } back_state_t;

endpackage : spe_pkg
`default_nettype wire

>>> rtl/spe_front.sv
// Front end: accepts requests, classifies them and holds them in a short command queue.
`timescale 1ns / 1ps
`default_nettype none
module spe_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic                       kind,
  input  logic                       first_term,
  input  logic signed [31:0]         coefficient,
  input  logic [5:0]                 exponent,
  input  logic signed [31:0]         eval_point,
  output spe_pkg::cmd_req_t          cmd_req,
  input  logic                       cmd_pop
);
  import spe_pkg::*;

  cmd_t                   entries [CMD_Q_DEPTH];
  logic [CMD_Q_PTR_W-1:0] wr_ptr;
  logic [CMD_Q_PTR_W-1:0] rd_ptr;
  logic [CMD_Q_CNT_W-1:0] count;
  cmd_t                   cmd_in;
  logic                   do_push;
  logic                   do_pop;

  // An evaluate carries its point in the operand slot, an add its coefficient.
  always_comb begin
    cmd_in.kind       = kind_t'(kind);
    cmd_in.first_term = first_term;
    cmd_in.operand    = (kind_t'(kind) == KIND_EVAL) ? eval_point : coefficient;
    cmd_in.exponent   = exponent;
  end

  assign full          = (count == CMD_Q_CNT_W'(CMD_Q_DEPTH));
  assign do_push       = push && !full;
  assign do_pop        = cmd_pop && cmd_req.valid;
  assign cmd_req.valid = (count != '0);
  assign cmd_req.cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == CMD_Q_PTR_W'(CMD_Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == CMD_Q_PTR_W'(CMD_Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule : spe_front
`default_nettype wire

>>> rtl/spe_back.sv
// Back end: term table, shared multiplier and the sequencer that executes requests.
`timescale 1ns / 1ps
`default_nettype none
module spe_back (
  input  logic                 clk,
  input  logic                 rst,
  input  spe_pkg::cmd_req_t    cmd_req,
  output logic                 cmd_pop,
  output logic                 res_push,
  output spe_pkg::res_t        res,
  input  logic                 res_full
);
  import spe_pkg::*;

  back_state_t              state;
  back_state_t              state_next;

  term_t                    mem [MAX_TERMS];
  term_t                    rd_data;
  logic [TERM_IDX_W-1:0]    rd_addr;
  logic                     mem_we;
  logic [TERM_CNT_W-1:0]    wr_idx;
  logic                     add_ok;

  logic [TERM_CNT_W-1:0]    term_count;
  logic                     overflow_seen;
  logic [TERM_CNT_W-1:0]    term_idx;

  logic [DATA_W-1:0]        x_pow [EXP_W];
  logic [DATA_W-1:0]        sq;
  logic [POW_IDX_W-1:0]     pow_idx;
  logic [POW_IDX_W-1:0]     bit_idx;
  logic [EXP_W-1:0]         exp_reg;
  logic [DATA_W-1:0]        acc;
  logic [DATA_W-1:0]        sum;

  logic [DATA_W-1:0]        mul_a;
  logic [DATA_W-1:0]        mul_b;
  logic [2*DATA_W-1:0]      mul_full;
  logic [DATA_W-1:0]        mul_p;

  // Only the low word of each product is kept, so everything wraps at 32 bits.
  assign mul_full = mul_a * mul_b;
  assign mul_p    = mul_full[DATA_W-1:0];

  assign wr_idx  = cmd_req.cmd.first_term ? '0 : term_count;
  assign add_ok  = cmd_req.cmd.first_term || (term_count != TERM_CNT_W'(MAX_TERMS));
  assign rd_addr = term_idx[TERM_IDX_W-1:0];

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_req.valid && (cmd_req.cmd.kind == KIND_EVAL)) begin
          state_next = (EXP_W > 1) ? ST_POW : ST_READ;
        end
      end
      ST_POW: begin
        if (pow_idx == POW_IDX_W'(EXP_W - 1)) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = (term_idx == term_count) ? ST_DONE : ST_LOAD;
      end
      ST_LOAD: state_next = ST_MUL;
      ST_MUL: begin
        if (bit_idx == POW_IDX_W'(EXP_W - 1)) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC:  state_next = ST_READ;
      ST_DONE: begin
        if (!res_full) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs and multiplier operands.
  always_comb begin
    cmd_pop  = 1'b0;
    mem_we   = 1'b0;
    res_push = 1'b0;
    mul_a    = sq;
    mul_b    = sq;
    unique case (state)
      ST_IDLE: begin
        cmd_pop = cmd_req.valid;
        mem_we  = cmd_req.valid && (cmd_req.cmd.kind == KIND_ADD) && add_ok;
      end
      ST_MUL: begin
        mul_a = acc;
        mul_b = exp_reg[bit_idx] ? x_pow[bit_idx] : DATA_W'(1);
      end
      ST_DONE: res_push = !res_full;
      default: ;
    endcase
  end

  assign res.poly_value    = sum;
  assign res.terms_dropped = overflow_seen;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx[TERM_IDX_W-1:0]] <= '{coef: cmd_req.cmd.operand, exp: cmd_req.cmd.exponent};
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      term_count    <= '0;
      overflow_seen <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && cmd_req.valid && cmd_req.cmd.kind == KIND_ADD) begin
        if (add_ok) begin
          term_count <= wr_idx + 1'b1;
        end else begin
          overflow_seen <= 1'b1;
        end
      end
      if (res_push) begin
        overflow_seen <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        sq       <= cmd_req.cmd.operand;
        x_pow[0] <= cmd_req.cmd.operand;
        pow_idx  <= POW_IDX_W'(1);
        sum      <= '0;
        term_idx <= '0;
      end
      ST_POW: begin
        sq             <= mul_p;
        x_pow[pow_idx] <= mul_p;
        pow_idx        <= pow_idx + 1'b1;
      end
      ST_LOAD: begin
        acc     <= rd_data.coef;
        exp_reg <= rd_data.exp;
        bit_idx <= '0;
      end
      ST_MUL: begin
        acc     <= mul_p;
        bit_idx <= bit_idx + 1'b1;
      end
      ST_ACC: begin
        sum      <= sum + acc;
        term_idx <= term_idx + 1'b1;
      end
      default: ;
    endcase
  end

endmodule : spe_back
`default_nettype wire

>>> rtl/spe_res_q.sv
// Result queue that holds finished results until the consumer pops them.
`timescale 1ns / 1ps
`default_nettype none
module spe_res_q (
  input  logic                clk,
  input  logic                rst,
  input  logic                res_push,
  input  spe_pkg::res_t       res,
  output logic                res_full,
  input  logic                pop,
  output logic                empty,
  output logic signed [31:0]  poly_value,
  output logic                terms_dropped
);
  import spe_pkg::*;

  res_t                   entries [RES_Q_DEPTH];
  logic [RES_Q_PTR_W-1:0] wr_ptr;
  logic [RES_Q_PTR_W-1:0] rd_ptr;
  logic [RES_Q_CNT_W-1:0] count;
  logic                   do_push;
  logic                   do_pop;

  assign res_full      = (count == RES_Q_CNT_W'(RES_Q_DEPTH));
  assign empty         = (count == '0);
  assign do_push       = res_push && !res_full;
  assign do_pop        = pop && !empty;
  assign poly_value    = entries[rd_ptr].poly_value;
  assign terms_dropped = entries[rd_ptr].terms_dropped;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == RES_Q_PTR_W'(RES_Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == RES_Q_PTR_W'(RES_Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule : spe_res_q
`default_nettype wire

>>> rtl/sparse_polynomial_evaluator_core.sv
// Top level of the sparse polynomial evaluator: command queue, execution unit and result queue.
`timescale 1ns / 1ps
`default_nettype none
// The block keeps a table of up to 16 terms, each a signed 32-bit coefficient
// and a 6-bit exponent. An add request appends a term (with first_term set it
// starts a new polynomial at entry 0); an add to a full table is dropped and
// the next result reports it in terms_dropped. An evaluate request returns
// the sum of coefficient * x^exponent over the stored terms, wrapped to 32
// bits, and an empty table gives 0. Add requests produce no result. Requests
// enter a four-deep command queue and are executed strictly in order by one
// execution unit, so the front can keep taking requests while an evaluation
// runs. The execution unit handles an add while it is idle. An evaluate first
// latches x, builds x^1, x^2, ..., x^32 by repeated squaring, then per term
// does the registered table read, loads the term, multiplies once per
// exponent bit through the single shared 32x32 multiplier and accumulates,
// and finally hands the result over. Results wait in a two-deep result
// queue; when it is full the execution unit holds its finished result until
// the consumer pops one. Reset is synchronous and clears the term count and
// the dropped-add flag; the table contents need no clearing because only
// entries below the count are ever used.
module sparse_polynomial_evaluator_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               kind,
  input  logic               first_term,
  input  logic signed [31:0] coefficient,
  input  logic [5:0]         exponent,
  input  logic signed [31:0] eval_point,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] poly_value,
  output logic               terms_dropped
);
  import spe_pkg::*;

  cmd_req_t cmd_req;
  logic     cmd_pop;
  logic     res_push;
  res_t     res;
  logic     res_full;

  // Front end: takes a request whenever the command queue has room.
  spe_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .kind        (kind),
    .first_term  (first_term),
    .coefficient (coefficient),
    .exponent    (exponent),
    .eval_point  (eval_point),
    .cmd_req     (cmd_req),
    .cmd_pop     (cmd_pop)
  );

  // Execution unit: owns the term table and the multiplier.
  spe_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_req  (cmd_req),
    .cmd_pop  (cmd_pop),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full)
  );

  // Result queue: decouples finished results from the consumer.
  spe_res_q u_res_q (
    .clk           (clk),
    .rst           (rst),
    .res_push      (res_push),
    .res           (res),
    .res_full      (res_full),
    .pop           (pop),
    .empty         (empty),
    .poly_value    (poly_value),
    .terms_dropped (terms_dropped)
  );

endmodule : sparse_polynomial_evaluator_core
`default_nettype wire
